/* sv/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; ASSERT_CLK expects clk and rst_n in scope, ASSERT_CLK_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/sslsup_pkg.sv */
// Types, codes and helpers for the scanner/scale link supervisor.
// No dependencies; imported by every module of the block.
package sslsup_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int MAX_RES = 4;

  localparam logic [7:0] READY_TO_RST = 8'd3;
  localparam logic [7:0] STARTUP_TO_RST = 8'd6;
  localparam logic [31:0] ZERO_CHARS = 32'h3030_3030;

  // register index, taken from paddr[2]
  localparam logic REG_READY_TO = 1'b0;
  localparam logic REG_STARTUP_TO = 1'b1;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SILENCE = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  localparam logic [3:0] KIND_S08 = 4'd0;
  localparam logic [3:0] KIND_S03 = 4'd1;
  localparam logic [3:0] KIND_S11 = 4'd2;
  localparam logic [3:0] KIND_S13 = 4'd3;
  localparam logic [3:0] KIND_S140 = 4'd4;
  localparam logic [3:0] KIND_S141 = 4'd5;
  localparam logic [3:0] KIND_S142 = 4'd6;
  localparam logic [3:0] KIND_S143 = 4'd7;
  localparam logic [3:0] KIND_S144 = 4'd8;
  localparam logic [3:0] KIND_S145 = 4'd9;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_S14 = 3'd1;
  localparam logic [2:0] CMD_S334 = 3'd2;
  localparam logic [2:0] CMD_S01 = 3'd3;
  localparam logic [2:0] CMD_S11 = 3'd4;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_LONG = 2'd1;
  localparam logic [1:0] BEEP_SHORT = 2'd2;

  localparam logic [1:0] PUB_NONE = 2'd0;
  localparam logic [1:0] PUB_SCAN = 2'd1;
  localparam logic [1:0] PUB_WEIGHT = 2'd2;
  localparam logic [1:0] PUB_ZERO = 2'd3;

  localparam logic [1:0] MCODE_STARTUP = 2'd0;
  localparam logic [1:0] MCODE_READY = 2'd1;
  localparam logic [1:0] MCODE_WEIGHING = 2'd2;
  localparam logic [1:0] MCODE_FAULT = 2'd3;

  typedef enum logic [3:0] {
    MODE_STARTUP = 4'b0001,
    MODE_READY = 4'b0010,
    MODE_WEIGHING = 4'b0100,
    MODE_FAULT = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] msg_kind;
    logic [31:0] weight_chars;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] beep;
    logic [1:0] publish;
    logic [31:0] published_weight;
    logic [1:0] mode_now;
    logic last_result;
  } out_item_t;

  typedef struct packed {
    logic [2:0] count;
    out_item_t [MAX_RES-1:0] entries;
  } eval_res_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      MODE_STARTUP: c = MCODE_STARTUP;
      MODE_READY: c = MCODE_READY;
      MODE_WEIGHING: c = MCODE_WEIGHING;
      MODE_FAULT: c = MCODE_FAULT;
      default: c = MCODE_STARTUP;
    endcase
    return c;
  endfunction

  function automatic out_item_t make_item(logic [2:0] cmd, logic [1:0] bp,
                                          logic [1:0] pub, logic [31:0] w,
                                          mode_t m);
    out_item_t r;
    r.command = cmd;
    r.beep = bp;
    r.publish = pub;
    r.published_weight = w;
    r.mode_now = mode_code(m);
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

/* sv/sslsup_eval.sv */
// Next-state and result-burst logic for one transaction of the link supervisor.
// Purely combinational; depends on sslsup_pkg.
module sslsup_eval (
  input  sslsup_pkg::mode_t     mode_r,
  input  logic [7:0]            quiet_r,
  input  logic [31:0]           prev_r,
  input  logic [7:0]            ready_to,
  input  logic [7:0]            startup_to,
  input  sslsup_pkg::in_item_t  item,
  output sslsup_pkg::mode_t     mode_nxt,
  output logic [7:0]            quiet_nxt,
  output logic [31:0]           prev_nxt,
  output sslsup_pkg::eval_res_t res
);
  import sslsup_pkg::*;

  always_comb begin
    logic [2:0] n;
    mode_t m;
    logic [7:0] q_inc;
    logic late;
    res = '0;
    n = 3'd0;
    m = mode_r;
    quiet_nxt = quiet_r;
    prev_nxt = prev_r;
    late = 1'b0;
    q_inc = (quiet_r == 8'hFF) ? quiet_r : quiet_r + 8'd1;
    case (item.operation)
      OP_TICK: begin
        quiet_nxt = q_inc;
        case (mode_r)
          MODE_READY, MODE_WEIGHING: late = q_inc > ready_to;
          MODE_STARTUP: late = q_inc > startup_to;
          default: late = 1'b0;
        endcase
        if (late) begin
          m = MODE_FAULT;
          res.entries[n[1:0]] = make_item(CMD_S14, BEEP_LONG, PUB_NONE, '0, m);
          n = n + 3'd1;
        end
      end
      OP_SILENCE: begin
        if (mode_r == MODE_FAULT) begin
          res.entries[n[1:0]] = make_item(CMD_S14, BEEP_NONE, PUB_NONE, '0, m);
          n = n + 3'd1;
        end
        res.entries[n[1:0]] = make_item(CMD_S14, BEEP_NONE, PUB_NONE, '0, m);
        n = n + 3'd1;
      end
      OP_REPLY: begin
        quiet_nxt = 8'd0;
        if (mode_r == MODE_FAULT) begin
          // back online: recovery command sequence
          m = MODE_READY;
          res.entries[0] = make_item(CMD_S334, BEEP_SHORT, PUB_NONE, '0, m);
          res.entries[1] = make_item(CMD_S01, BEEP_NONE, PUB_NONE, '0, m);
          res.entries[2] = make_item(CMD_S11, BEEP_NONE, PUB_NONE, '0, m);
          n = 3'd3;
        end
        case (item.msg_kind)
          KIND_S08: begin
            res.entries[n[1:0]] = make_item(CMD_NONE, BEEP_NONE, PUB_SCAN, '0, m);
            n = n + 3'd1;
          end
          KIND_S11: begin
            m = MODE_WEIGHING;
            if (item.weight_chars != prev_r) begin
              prev_nxt = item.weight_chars;
              res.entries[n[1:0]] = make_item(CMD_NONE, BEEP_NONE, PUB_WEIGHT,
                                              item.weight_chars, m);
              n = n + 3'd1;
            end
          end
          KIND_S140: m = MODE_STARTUP;
          KIND_S141, KIND_S142, KIND_S145: m = MODE_WEIGHING;
          KIND_S143: begin
            if (m != MODE_READY) begin
              m = MODE_READY;
              prev_nxt = ZERO_CHARS;
              res.entries[n[1:0]] = make_item(CMD_S11, BEEP_NONE, PUB_ZERO,
                                              ZERO_CHARS, m);
              n = n + 3'd1;
            end
          end
          KIND_S144: begin
            m = MODE_WEIGHING;
            if (item.weight_chars != prev_r) begin
              prev_nxt = item.weight_chars;
              res.entries[n[1:0]] = make_item(CMD_S334, BEEP_NONE, PUB_WEIGHT,
                                              item.weight_chars, m);
              n = n + 3'd1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    mode_nxt = m;
    res.count = n;
    if (n != 3'd0) begin
      res.entries[n[1:0] - 2'd1].last_result = 1'b1;
    end
  end

endmodule

/* sv/scale_scanner_link_supervisor_core.sv */
// The first result of a transaction is shown in the cycle after it is accepted.
// Throughput: one transaction per cycle while each gives at most one result and none
// stalls; a transaction with several results holds the result register until the last is
// taken, and the next input is taken in the cycle its last result is taken.
// Reset (synchronous, rst_n low): startup mode, quiet count 0, stored weight
// "0000", timeouts 3 and 6 seconds, result register empty.
module scale_scanner_link_supervisor_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  sslsup_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output sslsup_pkg::out_item_t                 out_data,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sslsup_pkg::ADDR_W-1:0]         paddr,
  input  logic [sslsup_pkg::DATA_W-1:0]         pwdata,
  output logic [sslsup_pkg::DATA_W-1:0]         prdata,
  output logic                                  pready
);
  import sslsup_pkg::*;

  logic [7:0] ready_to_r;
  logic [7:0] startup_to_r;
  mode_t mode_r;
  mode_t mode_nxt;
  logic [7:0] quiet_r;
  logic [7:0] quiet_nxt;
  logic [31:0] prev_r;
  logic [31:0] prev_nxt;
  eval_res_t res;

  out_item_t [MAX_RES-1:0] burst_r;
  logic [1:0] idx_r;
  logic [1:0] top_r;
  logic busy_r;

  logic in_take;
  logic out_take;
  logic burst_done;
  logic cfg_wr;

  sslsup_eval u_eval (
    .mode_r     (mode_r),
    .quiet_r    (quiet_r),
    .prev_r     (prev_r),
    .ready_to   (ready_to_r),
    .startup_to (startup_to_r),
    .item       (in_data),
    .mode_nxt   (mode_nxt),
    .quiet_nxt  (quiet_nxt),
    .prev_nxt   (prev_nxt),
    .res        (res)
  );

  assign out_valid = busy_r;
  assign out_data = burst_r[idx_r];
  assign out_take = busy_r && !out_stall;
  assign burst_done = out_take && (idx_r == top_r);
  assign in_stall = busy_r && !burst_done;
  assign in_take = in_valid && !in_stall;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_STARTUP_TO) ? {{(DATA_W-8){1'b0}}, startup_to_r}
                                               : {{(DATA_W-8){1'b0}}, ready_to_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_to_r <= READY_TO_RST;
      startup_to_r <= STARTUP_TO_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_STARTUP_TO) begin
        startup_to_r <= pwdata[7:0];
      end else begin
        ready_to_r <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STARTUP;
      quiet_r <= 8'd0;
      prev_r <= ZERO_CHARS;
    end else if (in_take) begin
      mode_r <= mode_nxt;
      quiet_r <= quiet_nxt;
      prev_r <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= 2'd0;
      top_r <= 2'd0;
    end else if (in_take && res.count != 3'd0) begin
      busy_r <= 1'b1;
      idx_r <= 2'd0;
      top_r <= res.count[1:0] - 2'd1;
    end else if (burst_done) begin
      busy_r <= 1'b0;
    end else if (out_take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res.count != 3'd0) begin
      burst_r <= res.entries;
    end
  end

endmodule

/* sv/sslsup_checker.sv */
// Port-level assertions for the link supervisor, bound to the top level.
// Depends on sslsup_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sslsup_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input sslsup_pkg::out_item_t out_data,
  input logic                  pready
);
  import sslsup_pkg::*;

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // a new transaction enters only as the last pending result leaves
  `ASSERT_CLK(a_in_after_burst, in_valid && !in_stall && out_valid |-> !out_stall && out_data.last_result, "input taken over pending results")

  `ASSERT_CLK(a_weight_zeroed, out_valid && out_data.publish != PUB_WEIGHT && out_data.publish != PUB_ZERO |-> out_data.published_weight == '0, "weight shown without publish")

  `ASSERT_CLK(a_fault_beep, out_valid && out_data.beep == BEEP_LONG |-> out_data.command == CMD_S14 && out_data.mode_now == MCODE_FAULT, "fault beep without fault")

  `ASSERT_CLK_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind scale_scanner_link_supervisor_core sslsup_checker u_sslsup_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

/* tb/sv/tb_scale_scanner_link_supervisor_core.sv */
// Self-checking bench for the scanner/scale link supervisor core.
// Needs only sslsup_pkg and scale_scanner_link_supervisor_core; a clocked driver,
// a monitor and an in-bench prediction of the link supervisor's reports.
module tb_scale_scanner_link_supervisor_core;
  import sslsup_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [3:0] KIND_OTHER = 4'd10;
  localparam logic [3:0] KIND_LAST = 4'd15;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  scale_scanner_link_supervisor_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // link events waiting to be driven, and reports predicted but not yet seen
  in_item_t link_events_q[$];
  out_item_t predicted_reports_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit event_taken = 1'b0;
  int cycle_count = 0;
  int mismatches = 0;
  int events_taken = 0;
  int reports_seen = 0;
  int faults_entered = 0;
  int recoveries = 0;

  // predicted supervisor state
  logic [7:0] ready_limit = READY_TO_RST;
  logic [7:0] startup_limit = STARTUP_TO_RST;
  logic [1:0] link_mode = MCODE_STARTUP;
  logic [7:0] quiet_secs = 8'd0;
  logic [31:0] stored_weight = ZERO_CHARS;
  out_item_t step_reports[MAX_RES];
  int step_count;

  function automatic void add_report(logic [2:0] cmd, logic [1:0] bp, logic [1:0] pub,
                                     logic [31:0] w);
    out_item_t r;
    r.command = cmd;
    r.beep = bp;
    r.publish = pub;
    r.published_weight = w;
    r.mode_now = link_mode;
    r.last_result = 1'b0;
    step_reports[step_count] = r;
    step_count++;
  endfunction

  function automatic void supervise_link(in_item_t ev);
    bit late;
    late = 1'b0;
    step_count = 0;
    case (ev.operation)
      OP_TICK: begin
        if (quiet_secs != 8'hFF) quiet_secs = quiet_secs + 8'd1;
        if (link_mode == MCODE_READY || link_mode == MCODE_WEIGHING)
          late = quiet_secs > ready_limit;
        else if (link_mode == MCODE_STARTUP)
          late = quiet_secs > startup_limit;
        if (late) begin
          link_mode = MCODE_FAULT;
          faults_entered++;
          add_report(CMD_S14, BEEP_LONG, PUB_NONE, '0);
        end
      end
      OP_SILENCE: begin
        // in fault the fault pass sends its own S14 first
        if (link_mode == MCODE_FAULT) add_report(CMD_S14, BEEP_NONE, PUB_NONE, '0);
        add_report(CMD_S14, BEEP_NONE, PUB_NONE, '0);
      end
      OP_REPLY: begin
        quiet_secs = 8'd0;
        if (link_mode == MCODE_FAULT) begin
          link_mode = MCODE_READY;
          recoveries++;
          add_report(CMD_S334, BEEP_SHORT, PUB_NONE, '0);
          add_report(CMD_S01, BEEP_NONE, PUB_NONE, '0);
          add_report(CMD_S11, BEEP_NONE, PUB_NONE, '0);
        end
        case (ev.msg_kind)
          KIND_S08: add_report(CMD_NONE, BEEP_NONE, PUB_SCAN, '0);
          KIND_S11: begin
            link_mode = MCODE_WEIGHING;
            if (ev.weight_chars != stored_weight) begin
              stored_weight = ev.weight_chars;
              add_report(CMD_NONE, BEEP_NONE, PUB_WEIGHT, ev.weight_chars);
            end
          end
          KIND_S140: link_mode = MCODE_STARTUP;
          KIND_S141, KIND_S142, KIND_S145: link_mode = MCODE_WEIGHING;
          KIND_S143: begin
            if (link_mode != MCODE_READY) begin
              link_mode = MCODE_READY;
              stored_weight = ZERO_CHARS;
              add_report(CMD_S11, BEEP_NONE, PUB_ZERO, ZERO_CHARS);
            end
          end
          KIND_S144: begin
            link_mode = MCODE_WEIGHING;
            if (ev.weight_chars != stored_weight) begin
              stored_weight = ev.weight_chars;
              add_report(CMD_S334, BEEP_NONE, PUB_WEIGHT, ev.weight_chars);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (step_count > 0) step_reports[step_count-1].last_result = 1'b1;
    for (int i = 0; i < step_count; i++) predicted_reports_q.push_back(step_reports[i]);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      event_taken = rst_n && in_valid && !in_stall;
      if (event_taken) begin
        supervise_link(in_data);
        events_taken++;
      end
      if (rst_n && out_valid && !out_stall) begin
        reports_seen++;
        if (predicted_reports_q.size() == 0) begin
          $error("report with nothing expected: %p", out_data);
          mismatches++;
        end else begin
          want = predicted_reports_q.pop_front();
          check_field("command", want.command, out_data.command);
          check_field("beep", want.beep, out_data.beep);
          check_field("publish", want.publish, out_data.publish);
          check_field("published_weight", want.published_weight, out_data.published_weight);
          check_field("mode_now", want.mode_now, out_data.mode_now);
          check_field("last_result", want.last_result, out_data.last_result);
        end
      end
    end
  end

  // driver: move to the next event only once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || event_taken) begin
        if (link_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= link_events_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic queue_event(logic [1:0] op, logic [3:0] kind, logic [31:0] w);
    in_item_t ev;
    ev.operation = op;
    ev.msg_kind = kind;
    ev.weight_chars = w;
    link_events_q.push_back(ev);
  endtask

  function automatic in_item_t random_event();
    in_item_t ev;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) ev.operation = OP_TICK;
    else if (pick < 52) ev.operation = OP_SILENCE;
    else if (pick < 95) ev.operation = OP_REPLY;
    else ev.operation = OP_UNUSED;
    if ($urandom_range(9) < 8) ev.msg_kind = 4'($urandom_range(KIND_S145));
    else ev.msg_kind = 4'($urandom_range(KIND_LAST, KIND_OTHER));
    // mostly a few nearby weights so that repeats hit the unchanged-weight path
    case ($urandom_range(3))
      0: ev.weight_chars = ZERO_CHARS;
      1, 2: ev.weight_chars = ZERO_CHARS + $urandom_range(2);
      default: ev.weight_chars = $urandom;
    endcase
    return ev;
  endfunction

  task automatic queue_random(int count);
    int added;
    int burst;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 15) begin
        // a quiet stretch of ticks that can run into the timeouts
        burst = $urandom_range(8, 1);
        repeat (burst) queue_event(OP_TICK, 4'($urandom), $urandom);
        added += burst;
      end else begin
        link_events_q.push_back(random_event());
        added++;
      end
    end
  endtask

  task automatic wait_drain();
    while (link_events_q.size() != 0 || in_valid || predicted_reports_q.size() != 0)
      @(posedge clk);
    // events with no report may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic regsel, logic [7:0] val);
    logic [DATA_W-1:0] readback;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= {24'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (regsel == REG_READY_TO) ready_limit = val;
    else startup_limit = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[7:0] !== val) begin
      $error("timeout register %0d: expected %0h, got %0h", regsel, val, readback[7:0]);
      mismatches++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass at the reset timeouts
    send_idle_pct = 13;
    recv_idle_pct = 67;
    queue_event(OP_UNUSED, KIND_LAST, '1);
    repeat (7) queue_event(OP_TICK, KIND_S08, '0);
    queue_event(OP_SILENCE, KIND_S03, '0);
    queue_event(OP_TICK, KIND_S11, '1);
    queue_event(OP_REPLY, KIND_S08, '1);
    queue_event(OP_REPLY, KIND_S11, '1);
    queue_event(OP_REPLY, KIND_S11, '1);
    queue_event(OP_REPLY, KIND_S144, '0);
    queue_event(OP_REPLY, KIND_S143, '0);
    queue_event(OP_REPLY, KIND_S143, '1);
    queue_event(OP_REPLY, KIND_S03, '1);
    queue_event(OP_REPLY, KIND_S13, '1);
    queue_event(OP_REPLY, KIND_LAST, '1);
    queue_event(OP_REPLY, KIND_S140, '0);
    queue_event(OP_REPLY, KIND_S141, '0);
    queue_event(OP_REPLY, KIND_S142, '0);
    queue_event(OP_REPLY, KIND_S145, '0);
    queue_event(OP_SILENCE, KIND_LAST, '1);
    wait_drain();

    write_timeout(REG_READY_TO, 8'd0);
    write_timeout(REG_STARTUP_TO, 8'hFF);
    queue_random(6);
    wait_drain();

    // ready timeout at its top never expires; run the quiet count into saturation
    send_idle_pct = 67;
    recv_idle_pct = 13;
    write_timeout(REG_READY_TO, 8'hFF);
    write_timeout(REG_STARTUP_TO, 8'd0);
    queue_event(OP_REPLY, KIND_S141, ZERO_CHARS);
    repeat (140) queue_event(OP_TICK, 4'($urandom), $urandom);
    wait_drain();

    // same quiet stretch continues without idling, two ticks past saturation
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (117) queue_event(OP_TICK, 4'($urandom), $urandom);
    queue_event(OP_REPLY, KIND_S08, ZERO_CHARS);
    wait_drain();

    write_timeout(REG_READY_TO, 8'($urandom_range(6, 1)));
    write_timeout(REG_STARTUP_TO, 8'($urandom_range(10, 1)));
    queue_random(8);
    wait_drain();

    $display("Ran %0d link events through four timeout settings: %0d reports checked,",
             events_taken, reports_seen);
    $display("%0d fault entries and %0d link recoveries predicted.", faults_entered, recoveries);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/sslsup_pkg.sv
sv/sslsup_eval.sv
sv/scale_scanner_link_supervisor_core.sv
sv/sslsup_checker.sv
tb/sv/tb_scale_scanner_link_supervisor_core.sv
